/* rtl/core/sorted_timer_event_queue_macros.svh */
// Assertion macros shared by the timer event queue RTL.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef SORTED_TIMER_EVENT_QUEUE_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_MACROS_SVH

// Checked only while out of reset.
`define STQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define STQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/stq_pkg.sv */
// Package of the timer event queue: sizes, codes, word types, helpers.
// Used by the channel interfaces and the top level.
`timescale 1ns / 1ps
package stq_pkg;
	localparam int NUM_SLOTS = 16;
	localparam int TIME_BITS = 48;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = SLOT_W + 1;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_TICK   = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_REL      = 2'd0,
		MODE_ABS      = 2'd1,
		MODE_PERIODIC = 2'd2,
		MODE_RSVD     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_VALUE = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RSVD      = 2'd3
	} stat_code_t;

	typedef enum logic {
		KIND_FIRED    = 1'b0,
		KIND_COMPLETE = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OP,
		S_SCAN,
		S_FIRE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  slot_id;
		logic [1:0]  timer_mode;
		logic [47:0] period_or_time;
		logic        has_hook;
		logic [47:0] now;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  fired_slot;
		logic [1:0]  status;
		logic        deadline_valid;
		logic [47:0] deadline_delay;
		logic        last;
	} out_word_t;

	typedef struct packed {
		time_t expiry;
		time_t period;
		logic  periodic;
	} slot_entry_t;

	function automatic time_t fix_zero(input time_t t);
		fix_zero = (t == '0) ? time_t'(1) : t;
	endfunction
endpackage

/* rtl/core/stq_in_if.sv */
// Input channel of the timer event queue: valid, ready and one request word.
// Depends on stq_pkg.
`timescale 1ns / 1ps
interface stq_in_if import stq_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/stq_out_if.sv */
// Output channel of the timer event queue: valid, ready and one result word.
// Depends on stq_pkg.
`timescale 1ns / 1ps
interface stq_out_if import stq_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/sorted_timer_event_queue.sv */
// Top level of the timer event queue: slot memory, scan engine, result register.
// Depends on stq_pkg, stq_in_if, stq_out_if and the assertion macro header.
//
// Each request word is taken only while the block is idle. Slot times live in a
// memory with one write port and one registered read port, read slot by slot in
// each scan. An add, cancel or unused operation runs one scan; a tick runs one
// scan per fired slot, one that finds nothing more to fire and one for the final
// deadline. Each result word waits while the previous one has not been taken.
// The result register lets the block accept the next word while the completion
// is still waiting to be taken.
`timescale 1ns / 1ps
`include "sorted_timer_event_queue_macros.svh"
module sorted_timer_event_queue import stq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	stq_in_if.sink        req,
	stq_out_if.source     rsp
);
	state_t                 state_q, state_d;
	in_word_t               req_q;
	logic [NUM_SLOTS-1:0]   armed_q, fired_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   rd_v_s1;
	logic [SLOT_W-1:0]      rd_idx_s1;
	slot_entry_t            rdata_s1;
	slot_entry_t            mem [NUM_SLOTS];
	logic                   final_q, best_found_q;
	logic [SLOT_W-1:0]      best_idx_q;
	slot_entry_t            best_q;
	stat_code_t             status_q, status_d;
	logic                   out_v_q;
	out_word_t              out_q;

	logic                   issue, scan_done, slot_free, take, hit, in_range;
	logic                   start_scan, final_d, do_fire, load_done, op_exec;
	logic                   mem_we, consider;
	logic [SLOT_W-1:0]      mem_waddr, req_slot;
	slot_entry_t            mem_wdata;
	time_t                  add_exp;

	assign req_slot  = req_q.slot_id[SLOT_W-1:0];
	assign in_range  = 32'(req_q.slot_id) < NUM_SLOTS;
	assign issue     = (state_q == S_SCAN) && (32'(cnt_q) < NUM_SLOTS);
	assign scan_done = (state_q == S_SCAN) && !issue && !rd_v_s1;
	assign slot_free = !out_v_q || rsp.ready;
	assign take      = req.valid && req.ready;
	assign hit       = best_found_q && (best_q.expiry < req_q.now);
	assign consider  = rd_v_s1 && armed_q[rd_idx_s1] && (final_q || !fired_q[rd_idx_s1]);
	assign add_exp   = fix_zero((req_q.timer_mode == MODE_ABS) ? req_q.period_or_time
		: time_t'(req_q.period_or_time + req_q.now));

	always_comb begin
		state_d    = state_q;
		start_scan = 1'b0;
		final_d    = final_q;
		do_fire    = 1'b0;
		load_done  = 1'b0;
		op_exec    = 1'b0;
		status_d   = ST_OK;
		mem_we     = 1'b0;
		mem_waddr  = req_slot;
		mem_wdata  = '{expiry: add_exp, period: req_q.period_or_time,
			periodic: (req_q.timer_mode == MODE_PERIODIC)};
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					state_d = S_OP;
				end
			end
			S_OP: begin
				op_exec    = 1'b1;
				start_scan = 1'b1;
				final_d    = (req_q.op != OP_TICK);
				state_d    = S_SCAN;
				unique case (op_t'(req_q.op))
					OP_ADD: begin
						if (!req_q.has_hook || !in_range) begin
							status_d = ST_BAD_VALUE;
						end else begin
							mem_we = 1'b1;
						end
					end
					OP_CANCEL: begin
						if (!in_range) begin
							status_d = ST_BAD_VALUE;
						end else if (!armed_q[req_slot]) begin
							status_d = ST_NOT_FOUND;
						end
					end
					OP_TICK: status_d = ST_OK;
					default: status_d = ST_BAD_VALUE;
				endcase
			end
			S_SCAN: begin
				if (scan_done) begin
					if (final_q) begin
						state_d = S_DONE;
					end else if (hit) begin
						state_d = S_FIRE;
					end else begin
						start_scan = 1'b1;
						final_d    = 1'b1;
					end
				end
			end
			S_FIRE: begin
				if (slot_free) begin
					do_fire    = 1'b1;
					mem_we     = best_q.periodic;
					mem_waddr  = best_idx_q;
					mem_wdata  = '{expiry: fix_zero(time_t'(req_q.now + best_q.period)),
						period: best_q.period, periodic: 1'b1};
					start_scan = 1'b1;
					state_d    = S_SCAN;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					load_done = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[cnt_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			armed_q      <= '0;
			fired_q      <= '0;
			cnt_q        <= '0;
			rd_v_s1      <= 1'b0;
			final_q      <= 1'b0;
			best_found_q <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
			rd_v_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (consider && (!best_found_q || rdata_s1.expiry < best_q.expiry)) begin
				best_found_q <= 1'b1;
			end
			if (start_scan) begin
				cnt_q        <= '0;
				best_found_q <= 1'b0;
			end
			if (op_exec) begin
				fired_q <= '0;
				if (req_q.op == OP_ADD && status_d == ST_OK) begin
					armed_q[req_slot] <= 1'b1;
				end
				if (req_q.op == OP_CANCEL && status_d == ST_OK) begin
					armed_q[req_slot] <= 1'b0;
				end
			end
			if (do_fire) begin
				fired_q[best_idx_q] <= 1'b1;
				armed_q[best_idx_q] <= best_q.periodic;
			end
			if (do_fire || load_done) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_q <= req.data;
		end
		rd_idx_s1 <= cnt_q[SLOT_W-1:0];
		if (op_exec) begin
			status_q <= status_d;
		end
		if (consider && (!best_found_q || rdata_s1.expiry < best_q.expiry)) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rdata_s1;
		end
		if (do_fire) begin
			out_q <= '{kind: KIND_FIRED, fired_slot: 4'(best_idx_q), status: ST_OK,
				deadline_valid: 1'b0, deadline_delay: '0, last: 1'b0};
		end else if (load_done) begin
			out_q <= '{kind: KIND_COMPLETE, fired_slot: '0, status: status_q,
				deadline_valid: best_found_q,
				deadline_delay: (best_found_q && best_q.expiry > req_q.now)
					? 48'(best_q.expiry - req_q.now) : '0,
				last: 1'b1};
		end
	end

	`STQ_ASSERT(a_accept_goes_op, take |=> (state_q == S_OP), "accepted word not executed")
	`STQ_ASSERT(a_fire_once, do_fire |-> !fired_q[best_idx_q], "slot fired twice in one tick")
	`STQ_ASSERT(a_fire_expired, do_fire |-> (best_q.expiry < req_q.now), "fired unexpired slot")
	`STQ_ASSERT_ALWAYS(a_read_in_scan, rd_v_s1 |-> (state_q == S_SCAN), "read outside scan")
endmodule

/* test/tb_top.sv */
// Self-checking testbench of sorted_timer_event_queue: timer add, cancel and tick words.
// Depends on stq_pkg, stq_in_if, stq_out_if and the block; predicts every result word.
`timescale 1ns / 1ps
module tb_top;
	import stq_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stq_in_if  req ();
	stq_out_if rsp ();

	sorted_timer_event_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #1 clk = ~clk;

	logic        armed [NUM_SLOTS];
	time_t       expiry [NUM_SLOTS];
	time_t       period [NUM_SLOTS];
	logic        periodic [NUM_SLOTS];

	in_word_t    pending_words [$];
	out_word_t   expected_results [$];

	int          mismatches = 0;
	int          words_sent = 0;
	int          results_seen = 0;
	int          fired_seen = 0;
	int          idle_cycles = 0;
	bit          timed_out = 0;
	bit          send_quiet = 0;
	bit          hold_until_empty = 0;
	bit          in_taken = 0;
	int          rx_hold = 0;
	bit          all_sent = 0;
	time_t       clock_now = '0;

	function automatic int earliest_slot(input logic skip [NUM_SLOTS]);
		int best;
		best = -1;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (armed[i] && !skip[i]) begin
				if (best < 0 || expiry[i] < expiry[best])
					best = i;
			end
		end
		return best;
	endfunction

	function automatic out_word_t make_word(input kind_t k, input int s, input stat_code_t st,
			input logic dv, input time_t d, input logic l);
		out_word_t w;
		w.kind = k;
		w.fired_slot = 4'(s);
		w.status = st;
		w.deadline_valid = dv;
		w.deadline_delay = d;
		w.last = l;
		return w;
	endfunction

	task automatic schedule_word(input in_word_t w);
		stat_code_t st;
		logic    fired [NUM_SLOTS];
		logic    none [NUM_SLOTS];
		time_t   t;
		int      e;
		st = ST_OK;
		foreach (fired[i]) begin
			fired[i] = 1'b0;
			none[i] = 1'b0;
		end
		case (op_t'(w.op))
			OP_ADD: begin
				if (!w.has_hook) begin
					st = ST_BAD_VALUE;
				end else begin
					t = w.period_or_time;
					if (mode_t'(w.timer_mode) != MODE_ABS)
						t = t + w.now;
					expiry[w.slot_id] = (t == '0) ? time_t'(1) : t;
					period[w.slot_id] = w.period_or_time;
					periodic[w.slot_id] = (mode_t'(w.timer_mode) == MODE_PERIODIC);
					armed[w.slot_id] = 1'b1;
				end
			end
			OP_CANCEL: begin
				if (!armed[w.slot_id])
					st = ST_NOT_FOUND;
				else
					armed[w.slot_id] = 1'b0;
			end
			OP_TICK: begin
				forever begin
					e = earliest_slot(fired);
					if (e < 0 || !(expiry[e] < w.now))
						break;
					fired[e] = 1'b1;
					armed[e] = 1'b0;
					expected_results.push_back(make_word(KIND_FIRED, e, ST_OK, 1'b0, '0, 1'b0));
					if (periodic[e]) begin
						t = w.now + period[e];
						expiry[e] = (t == '0) ? time_t'(1) : t;
						armed[e] = 1'b1;
					end
				end
			end
			default: st = ST_BAD_VALUE;
		endcase
		e = earliest_slot(none);
		if (e < 0)
			expected_results.push_back(make_word(KIND_COMPLETE, 0, st, 1'b0, '0, 1'b1));
		else
			expected_results.push_back(make_word(KIND_COMPLETE, 0, st, 1'b1,
				(expiry[e] > w.now) ? expiry[e] - w.now : '0, 1'b1));
	endtask

	function automatic in_word_t build_word(input op_t o, input int s, input mode_t m,
			input time_t pt, input logic hook, input time_t n);
		in_word_t w;
		w.op = o;
		w.slot_id = 4'(s);
		w.timer_mode = m;
		w.period_or_time = pt;
		w.has_hook = hook;
		w.now = n;
		return w;
	endfunction

	function automatic time_t random_time();
		time_t t;
		t = time_t'({$urandom(), $urandom()});
		return t;
	endfunction

	function automatic time_t random_delay();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return random_time();
			2: return {TIME_BITS{1'b1}} - time_t'($urandom_range(0, 3));
			default: return time_t'($urandom_range(0, 400));
		endcase
	endfunction

	function automatic in_word_t random_word();
		int    pick;
		time_t n;
		if ($urandom_range(0, 19) == 0)
			clock_now = random_time();
		else
			clock_now = clock_now + time_t'($urandom_range(0, 150));
		n = clock_now;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return build_word(OP_ADD, $urandom_range(0, 15), mode_t'($urandom_range(0, 3)),
				($urandom_range(0, 3) == 0) ? n + time_t'($urandom_range(0, 300))
				: random_delay(), ($urandom_range(0, 9) != 0), n);
		else if (pick < 58)
			return build_word(OP_CANCEL, $urandom_range(0, 15), mode_t'($urandom_range(0, 3)),
				random_time(), 1'($urandom()), n);
		else if (pick < 97)
			return build_word(OP_TICK, $urandom_range(0, 15), mode_t'($urandom_range(0, 3)),
				random_time(), 1'($urandom()), n);
		else
			return build_word(OP_RSVD, $urandom_range(0, 15), mode_t'($urandom_range(0, 3)),
				random_time(), 1'($urandom()), n);
	endfunction

	// The driver presents the head of the pending queue and changes inputs on the falling edge.
	always @(negedge clk) begin
		bit gap;
		if (arst_n) begin
			gap = !send_quiet && ($urandom_range(0, 99) < 18);
			if (hold_until_empty && expected_results.size() == 0 && !(req.valid && !in_taken))
				hold_until_empty = 0;
			if (req.valid && !in_taken) begin
			end else if (pending_words.size() != 0 && !gap && !hold_until_empty) begin
				req.valid <= 1'b1;
				req.data <= pending_words[0];
			end else begin
				req.valid <= 1'b0;
			end
			in_taken = 0;
		end
	end

	// The receiver stalls at random, and for one long stretch after a run of words.
	always @(negedge clk) begin
		if (arst_n) begin
			if (words_sent == 200 && rx_hold == 0)
				rx_hold = 300;
			if (rx_hold > 1) begin
				rx_hold--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= send_quiet || ($urandom_range(0, 99) >= 18);
			end
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (req.valid && req.ready || rsp.valid && rsp.ready)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (req.valid && req.ready) begin
				schedule_word(pending_words.pop_front());
				words_sent++;
				in_taken = 1;
			end
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", rsp.data);
				end else begin
					want = expected_results.pop_front();
					if (want.kind == KIND_FIRED)
						fired_seen++;
					if (rsp.data !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %h, got %h", want, rsp.data);
					end
				end
			end
		end
	end

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		foreach (armed[i]) begin
			armed[i] = 1'b0;
			expiry[i] = '0;
			period[i] = '0;
			periodic[i] = 1'b0;
		end
		pending_words.push_back(build_word(OP_CANCEL, 3, MODE_REL, '0, 1'b1, 48'd10));
		pending_words.push_back(build_word(OP_TICK, 0, MODE_REL, '0, 1'b0, '0));
		pending_words.push_back(build_word(OP_ADD, 0, MODE_REL, 48'd5, 1'b0, 48'd10));
		pending_words.push_back(build_word(OP_ADD, 0, MODE_REL, 48'd5, 1'b1, 48'd10));
		pending_words.push_back(build_word(OP_ADD, 15, MODE_ABS, '1, 1'b1, 48'd10));
		pending_words.push_back(build_word(OP_ADD, 1, MODE_PERIODIC, 48'd5, 1'b1, 48'd10));
		pending_words.push_back(build_word(OP_ADD, 2, MODE_RSVD, 48'd3, 1'b1, 48'd12));
		pending_words.push_back(build_word(OP_ADD, 3, MODE_ABS, '0, 1'b1, 48'd12));
		pending_words.push_back(build_word(OP_ADD, 4, MODE_REL, 48'd1, 1'b1, '1));
		pending_words.push_back(build_word(OP_ADD, 5, MODE_PERIODIC, '0, 1'b1, 48'd14));
		pending_words.push_back(build_word(OP_ADD, 1, MODE_PERIODIC, 48'd5, 1'b1, 48'd10));
		pending_words.push_back(build_word(OP_TICK, 0, MODE_REL, '0, 1'b0, 48'd12));
		pending_words.push_back(build_word(OP_TICK, 0, MODE_REL, '0, 1'b0, 48'd20));
		pending_words.push_back(build_word(OP_TICK, 0, MODE_REL, '0, 1'b0, 48'd21));
		pending_words.push_back(build_word(OP_CANCEL, 1, MODE_REL, '0, 1'b1, 48'd22));
		pending_words.push_back(build_word(OP_CANCEL, 1, MODE_REL, '0, 1'b1, 48'd22));
		pending_words.push_back(build_word(OP_RSVD, 7, MODE_RSVD, '1, 1'b1, '1));
		for (int i = 0; i < NUM_SLOTS; i++)
			pending_words.push_back(build_word(OP_ADD, i, MODE_PERIODIC, 48'd2, 1'b1, 48'd100));
		pending_words.push_back(build_word(OP_TICK, 0, MODE_REL, '0, 1'b0, '1));
		pending_words.push_back(build_word(OP_TICK, 0, MODE_REL, '0, 1'b0, 48'd50));
		clock_now = 48'd1000;
		for (int i = 0; i < 445; i++)
			pending_words.push_back(random_word());
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		wait (words_sent == 100);
		hold_until_empty = 1;
		wait (words_sent == 300);
		send_quiet = 1;
		wait (words_sent == 380);
		send_quiet = 0;
		wait (pending_words.size() == 0 && expected_results.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d request words sent, %0d result words checked, %0d timer expiries.",
			words_sent, results_seen, fired_seen);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("sorted_timer_event_queue: match");
		else
			$display("sorted_timer_event_queue: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("sorted_timer_event_queue: mismatch");
			$finish;
		end
	end
endmodule
